// File: rtl/core/tcera_pkg.sv
// Package with the shared types and constants of the echo range averager.
`default_nettype none

package tcera_pkg;

  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned ECHO_W   = 16;
  localparam int unsigned DIST_W   = 11;
  localparam int unsigned MAX_DIST = 1126;

  localparam logic [ECHO_W-1:0] TIMEOUT_RESET = 16'd6000;
  localparam logic [11:0]       LEFT_SCALE    = 12'd1114;
  localparam logic [11:0]       SIDE_SCALE    = 12'd2252;

  typedef enum logic [1:0] {
    CH_LEFT   = 2'd0,
    CH_RIGHT  = 2'd1,
    CH_MIDDLE = 2'd2
  } chan_t;

endpackage

`default_nettype wire

// File: rtl/core/three_channel_echo_range_averager_unit.sv
// Top level of the three-channel echo range averager.
`default_nettype none

// Each transaction carries one echo width for the sensor whose turn it is, in the order left,
// right, middle. The unit accepts one transaction per clock cycle unless a result is stalled,
// and each passes through the stages in turn: the first stage converts the width to centimeters
// with one multiplier and reads the oldest ring entry, the second updates the ring memory and the
// running sum, and the third divides all three sums by DEPTH through a reciprocal multiply into
// the output register. A stalled result freezes the whole pipeline. The rings read as zero after
// reset through valid bits, so no clearing pass is needed.
module three_channel_echo_range_averager_unit
  import tcera_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [ECHO_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ECHO_W-1:0] in_echo_us,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_channel,
  output logic [DIST_W-1:0]      out_new_distance,
  output logic [DIST_W-1:0]      out_left_average,
  output logic [DIST_W-1:0]      out_right_average,
  output logic [DIST_W-1:0]      out_middle_average
);

  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned ENTRIES  = NUM_CH * DEPTH;
  localparam int unsigned ADDR_W   = $clog2(ENTRIES);
  localparam int unsigned SUM_W    = $clog2(DEPTH * MAX_DIST + 1);
  localparam int unsigned DIV_SH   = SUM_W + PTR_W;
  localparam int unsigned RECIP    = ((1 << DIV_SH) + DEPTH - 1) / DEPTH;
  localparam int unsigned RECIP_W  = SUM_W + 1;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic              adv;
  logic              in_accept;
  logic [ECHO_W-1:0] echo_timeout_r;

  chan_t             turn_r;
  chan_t             turn_nxt;
  logic [PTR_W-1:0]  ptr_r [NUM_CH];
  logic [PTR_W-1:0]  ptr_sel;
  logic [PTR_W-1:0]  ptr_nxt;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic [ECHO_W-1:0] echo_eff;
  logic [ECHO_W-1:0] mul_a;
  logic [11:0]       mul_b;
  logic [27:0]       mul_p;

  logic              s1_valid_r;
  chan_t             s1_ch_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DIST_W-1:0] s1_dist_r;
  logic [DIST_W-1:0] old_dist;

  logic [SUM_W-1:0]  sum_r [NUM_CH];
  logic [SUM_W-1:0]  sum_sel;
  logic [SUM_W-1:0]  sum_upd;
  logic [SUM_W-1:0]  sum_nxt [NUM_CH];

  logic              s2_valid_r;
  chan_t             s2_ch_r;
  logic [DIST_W-1:0] s2_dist_r;
  logic [SUM_W-1:0]  s2_sum_r [NUM_CH];
  logic [PROD_W-1:0] avg_p [NUM_CH];

  logic              out_valid_r;
  chan_t             out_ch_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [DIST_W-1:0] out_avg_r [NUM_CH];

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      echo_timeout_r <= cfg_wr_data;
    end
  end

  always_comb begin
    case (turn_r)
      CH_LEFT: begin
        ptr_sel   = ptr_r[0];
        base_addr = '0;
        turn_nxt  = CH_RIGHT;
      end
      CH_RIGHT: begin
        ptr_sel   = ptr_r[1];
        base_addr = ADDR_W'(DEPTH);
        turn_nxt  = CH_MIDDLE;
      end
      CH_MIDDLE: begin
        ptr_sel   = ptr_r[2];
        base_addr = ADDR_W'(2 * DEPTH);
        turn_nxt  = CH_LEFT;
      end
      default: begin
        ptr_sel   = ptr_r[0];
        base_addr = '0;
        turn_nxt  = CH_LEFT;
      end
    endcase
  end

  assign ptr_nxt = (ptr_sel == PTR_W'(DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
  assign rd_addr = base_addr + ADDR_W'(ptr_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r <= CH_LEFT;
      for (int k = 0; k < NUM_CH; k++) begin
        ptr_r[k] <= '0;
      end
    end else if (in_accept) begin
      turn_r <= turn_nxt;
      for (int k = 0; k < NUM_CH; k++) begin
        if (turn_r == 2'(k)) begin
          ptr_r[k] <= ptr_nxt;
        end
      end
    end
  end

  assign echo_eff = (in_echo_us > echo_timeout_r) ? '0 : in_echo_us;
  assign mul_a    = (turn_r == CH_LEFT) ? echo_eff : {1'b0, echo_eff[ECHO_W-1:1]};
  assign mul_b    = (turn_r == CH_LEFT) ? LEFT_SCALE : SIDE_SCALE;
  assign mul_p    = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ch_r   <= turn_r;
      s1_addr_r <= rd_addr;
      s1_dist_r <= mul_p[16 +: DIST_W];
    end
  end

  tcera_ring_store #(
    .ENTRIES (ENTRIES)
  ) u_ring_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (old_dist),
    .wr_en   (adv && s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (s1_dist_r)
  );

  always_comb begin
    case (s1_ch_r)
      CH_LEFT:   sum_sel = sum_r[0];
      CH_RIGHT:  sum_sel = sum_r[1];
      CH_MIDDLE: sum_sel = sum_r[2];
      default:   sum_sel = sum_r[0];
    endcase
  end

  assign sum_upd = sum_sel - SUM_W'(old_dist) + SUM_W'(s1_dist_r);

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum_nxt[k] = (s1_ch_r == 2'(k)) ? sum_upd : sum_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CH; k++) begin
        sum_r[k] <= '0;
      end
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        for (int k = 0; k < NUM_CH; k++) begin
          sum_r[k] <= sum_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_ch_r   <= s1_ch_r;
      s2_dist_r <= s1_dist_r;
      for (int k = 0; k < NUM_CH; k++) begin
        s2_sum_r[k] <= sum_nxt[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      avg_p[k] = PROD_W'(s2_sum_r[k]) * PROD_W'(RECIP_C);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_ch_r   <= s2_ch_r;
      out_dist_r <= s2_dist_r;
      for (int k = 0; k < NUM_CH; k++) begin
        out_avg_r[k] <= avg_p[k][DIV_SH +: DIST_W];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_ch_r;
  assign out_new_distance   = out_dist_r;
  assign out_left_average   = out_avg_r[0];
  assign out_right_average  = out_avg_r[1];
  assign out_middle_average = out_avg_r[2];

endmodule

`default_nettype wire

// File: rtl/core/tcera_ring_store.sv
// Distance ring memory with per-entry valid bits that read as zero until written.
`default_nettype none

module tcera_ring_store
  import tcera_pkg::*;
#(
  parameter int unsigned ENTRIES = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic      [DIST_W-1:0]          rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  wire logic [DIST_W-1:0]          wr_data
);

  logic [DIST_W-1:0]  mem [ENTRIES];
  logic [DIST_W-1:0]  mem_q_r;
  logic               hit_r;
  logic [ENTRIES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = hit_r ? mem_q_r : '0;

endmodule

`default_nettype wire
